// ===== sv/uafs_pkg.sv =====
// Package: shared constants and register indexes of the UBX frame separator.
package uafs_pkg;
    localparam int unsigned BUFFER_BYTES_DEF = 64;
    localparam int unsigned MAX_PAYLOAD_DEF  = 56;
    localparam int unsigned FRAME_OVERHEAD   = 8;
    localparam int unsigned HEADER_BYTES     = 6;

    localparam logic [7:0] SYNC1_RST = 8'd181;
    localparam logic [7:0] SYNC2_RST = 8'd98;
    localparam logic [7:0] CLASS_RST = 8'd19;
    localparam logic [5:0] LIMIT_RST = 6'd56;

    typedef enum logic [1:0] {
        REG_SYNC1 = 2'd0,
        REG_SYNC2 = 2'd1,
        REG_CLASS = 2'd2,
        REG_LIMIT = 2'd3
    } t_reg_idx;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
endpackage

// ===== sv/uafs_in_if.sv =====
// Interface: input channel carrying one action and stream byte per item.
interface uafs_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;
    modport source (output valid, action, in_byte, input ready);
    modport sink   (input valid, action, in_byte, output ready);
endinterface

// ===== sv/uafs_out_if.sv =====
// Interface: output channel carrying one settled byte and its tags per item.
interface uafs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_frame;
    logic       span_end;
    logic       step_last;
    modport source (output valid, out_byte, is_frame, span_end, step_last, input ready);
    modport sink   (input valid, out_byte, is_frame, span_end, step_last, output ready);
endinterface

// ===== sv/ubx_assist_frame_separator.sv =====
// Top level: UBX frame separator with a circular byte store and a scan sequencer.
//
//  channel   | dir | handshake       | payload
//  i_in      | in  | valid / ready   | action, in_byte
//  o_out     | out | valid / ready   | out_byte, is_frame, span_end, step_last
//  i_cfg_*   | in  | write enable    | register index, 8-bit data
//
// One item at a time: a push rescans every held byte through one registered memory
// read port, with a checksum pass over each candidate frame, and emits the results.
// A flush emits every held byte and empties the store. Reset is synchronous and
// clears the control state only; the store needs no clearing. A stalled output
// holds the sequencer at its next emitted byte.
module ubx_assist_frame_separator #(
    parameter int unsigned BUFFER_BYTES = uafs_pkg::BUFFER_BYTES_DEF,
    parameter int unsigned MAX_PAYLOAD  = uafs_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    uafs_in_if.sink    i_in,
    uafs_out_if.source o_out
);
    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned CAP_I = (MAX_PAYLOAD < BUFFER_BYTES - uafs_pkg::FRAME_OVERHEAD)
                                    ? MAX_PAYLOAD : BUFFER_BYTES - uafs_pkg::FRAME_OVERHEAD;
    localparam logic [5:0] LIM_CAP = 6'(CAP_I);
    localparam logic [CW-1:0] FLEN_BASE = CW'(uafs_pkg::FRAME_OVERHEAD);
    localparam logic [CW-1:0] HDR_LEN   = CW'(uafs_pkg::HEADER_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_C0, S_C0W, S_C1W, S_C2W, S_C4W, S_C5W, S_SUM, S_CKA, S_CKB,
        S_END, S_COMMIT, S_FIN, E_RD, E_WR
    } t_state;

    typedef enum logic [1:0] {
        K_PRE, K_FRAME, K_TAIL, K_FLUSH
    } t_kind;

    t_state r_state;
    t_kind  r_kind;

    logic [7:0] r_sync1, r_sync2, r_class;
    logic [5:0] r_limit;

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count, r_pos, r_raw, r_end, r_idx, r_em_idx, r_em_to;
    logic [7:0]    r_len_lo, r_ca, r_cb;
    logic          r_em_frame;

    logic       r_pend_v, r_pend_frame, r_pend_end;
    logic [7:0] r_pend_byte;
    logic       r_out_v, r_out_frame, r_out_end, r_out_last;
    logic [7:0] r_out_byte;

    logic          out_free, out_load, in_acc, mem_we;
    logic [5:0]    eff_lim;
    logic [CW-1:0] avail, flen;
    logic [7:0]    ca_n;
    logic [AW-1:0] wr_addr;

    function automatic logic [AW-1:0] f_addr(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off[AW-1:0]};
        if (sum >= (AW+1)'(BUFFER_BYTES)) begin
            sum = sum - (AW+1)'(BUFFER_BYTES);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free = !r_out_v || o_out.ready;
    // the output register takes the held-back result this cycle
    assign out_load = out_free && r_pend_v && ((r_state == S_FIN) || (r_state == E_WR));
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc = i_in.valid && (r_state == S_IDLE);
    assign eff_lim = (r_limit > LIM_CAP) ? LIM_CAP : r_limit;
    assign avail = r_count - r_pos;
    assign flen = FLEN_BASE + CW'(r_rdata[5:0] & 6'h00) + CW'(r_len_lo);
    assign ca_n = r_ca + r_rdata;
    assign mem_we = in_acc && (i_in.action == uafs_pkg::ACT_PUSH)
                    && (r_count < CW'(BUFFER_BYTES));
    assign wr_addr = f_addr(r_head, r_count);

    assign o_out.valid     = r_out_v;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.is_frame  = r_out_frame;
    assign o_out.span_end  = r_out_end;
    assign o_out.step_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_TAIL;
            r_sync1  <= uafs_pkg::SYNC1_RST;
            r_sync2  <= uafs_pkg::SYNC2_RST;
            r_class  <= uafs_pkg::CLASS_RST;
            r_limit  <= uafs_pkg::LIMIT_RST;
            r_head   <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_raw    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (uafs_pkg::t_reg_idx'(i_cfg_idx))
                    uafs_pkg::REG_SYNC1: r_sync1 <= i_cfg_data;
                    uafs_pkg::REG_SYNC2: r_sync2 <= i_cfg_data;
                    uafs_pkg::REG_CLASS: r_class <= i_cfg_data;
                    uafs_pkg::REG_LIMIT: r_limit <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_out_v && o_out.ready && !out_load) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.action == uafs_pkg::ACT_FLUSH) begin
                            if (r_count != '0) begin
                                r_em_idx   <= '0;
                                r_em_to    <= r_count;
                                r_em_frame <= 1'b0;
                                r_kind     <= K_FLUSH;
                                r_state    <= E_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            if (mem_we) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_pos   <= '0;
                            r_raw   <= '0;
                            r_state <= S_C0;
                        end
                    end
                end
                S_C0: begin
                    if (r_pos == r_count) begin
                        r_state <= S_END;
                    end else begin
                        r_rdata <= r_mem[f_addr(r_head, r_pos)];
                        r_state <= S_C0W;
                    end
                end
                S_C0W: begin
                    if (r_rdata != r_sync1) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_C0;
                    end else if (avail < CW'(2)) begin
                        r_state <= S_END;
                    end else begin
                        r_rdata <= r_mem[f_addr(r_head, r_pos + CW'(1))];
                        r_state <= S_C1W;
                    end
                end
                S_C1W: begin
                    if (r_rdata != r_sync2) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_C0;
                    end else if (avail < HDR_LEN) begin
                        r_state <= S_END;
                    end else begin
                        r_rdata <= r_mem[f_addr(r_head, r_pos + CW'(2))];
                        r_state <= S_C2W;
                    end
                end
                S_C2W: begin
                    if (r_rdata != r_class) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_C0;
                    end else begin
                        r_rdata <= r_mem[f_addr(r_head, r_pos + CW'(4))];
                        r_state <= S_C4W;
                    end
                end
                S_C4W: begin
                    r_len_lo <= r_rdata;
                    r_rdata  <= r_mem[f_addr(r_head, r_pos + CW'(5))];
                    r_state  <= S_C5W;
                end
                S_C5W: begin
                    // length high byte must be zero and low byte within the limit
                    if (r_rdata != 8'h00 || r_len_lo > {2'b00, eff_lim}) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_C0;
                    end else if (avail < flen) begin
                        r_state <= S_END;
                    end else begin
                        r_end   <= r_pos + flen;
                        r_idx   <= r_pos + CW'(2);
                        r_ca    <= '0;
                        r_cb    <= '0;
                        r_rdata <= r_mem[f_addr(r_head, r_pos + CW'(2))];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_ca <= ca_n;
                    r_cb <= r_cb + ca_n;
                    if (r_idx == r_end - CW'(3)) begin
                        r_rdata <= r_mem[f_addr(r_head, r_end - CW'(2))];
                        r_state <= S_CKA;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_rdata <= r_mem[f_addr(r_head, r_idx + CW'(1))];
                    end
                end
                S_CKA: begin
                    if (r_rdata != r_ca) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_C0;
                    end else begin
                        r_rdata <= r_mem[f_addr(r_head, r_end - CW'(1))];
                        r_state <= S_CKB;
                    end
                end
                S_CKB: begin
                    if (r_rdata != r_cb) begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_C0;
                    end else if (r_pos > r_raw) begin
                        r_em_idx   <= r_raw;
                        r_em_to    <= r_pos;
                        r_em_frame <= 1'b0;
                        r_kind     <= K_PRE;
                        r_state    <= E_RD;
                    end else begin
                        r_em_idx   <= r_pos;
                        r_em_to    <= r_end;
                        r_em_frame <= 1'b1;
                        r_kind     <= K_FRAME;
                        r_state    <= E_RD;
                    end
                end
                S_END: begin
                    if (r_pos > r_raw) begin
                        r_em_idx   <= r_raw;
                        r_em_to    <= r_pos;
                        r_em_frame <= 1'b0;
                        r_kind     <= K_TAIL;
                        r_state    <= E_RD;
                    end else begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    // drop the settled bytes from the front of the store
                    r_head  <= f_addr(r_head, r_pos);
                    r_count <= r_count - r_pos;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_v     <= 1'b1;
                        r_out_byte  <= r_pend_byte;
                        r_out_frame <= r_pend_frame;
                        r_out_end   <= r_pend_end;
                        r_out_last  <= 1'b1;
                        r_pend_v    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                E_RD: begin
                    r_rdata <= r_mem[f_addr(r_head, r_em_idx)];
                    r_state <= E_WR;
                end
                E_WR: begin
                    // hold one result back so the final one can carry step_last
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_out_v     <= 1'b1;
                            r_out_byte  <= r_pend_byte;
                            r_out_frame <= r_pend_frame;
                            r_out_end   <= r_pend_end;
                            r_out_last  <= 1'b0;
                        end
                        r_pend_v     <= 1'b1;
                        r_pend_byte  <= r_rdata;
                        r_pend_frame <= r_em_frame;
                        r_pend_end   <= (r_em_idx + CW'(1) == r_em_to);
                        if (r_em_idx + CW'(1) != r_em_to) begin
                            r_em_idx <= r_em_idx + CW'(1);
                            r_state  <= E_RD;
                        end else begin
                            case (r_kind)
                                K_PRE: begin
                                    r_em_idx   <= r_pos;
                                    r_em_to    <= r_end;
                                    r_em_frame <= 1'b1;
                                    r_kind     <= K_FRAME;
                                    r_state    <= E_RD;
                                end
                                K_FRAME: begin
                                    r_pos   <= r_end;
                                    r_raw   <= r_end;
                                    r_state <= S_C0;
                                end
                                K_TAIL: begin
                                    r_state <= S_COMMIT;
                                end
                                K_FLUSH: begin
                                    r_count <= '0;
                                    r_head  <= '0;
                                    r_state <= S_FIN;
                                end
                                default: r_state <= S_FIN;
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
